@@ hdl/assert_macros.svh @@
// assertion macros used by the rtl top
// each macro expects clk_i and rst_ni in the scope where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define HSFC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define HSFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/hsfc_pkg.sv @@
// package for the half/single float converter
// holds field widths, format constants and the operand class type
package hsfc_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned S_EXP_W    = 8;
  localparam int unsigned S_MANT_W   = 23;
  localparam int unsigned H_EXP_W    = 5;
  localparam int unsigned H_MANT_W   = 10;
  localparam int unsigned SHAMT_W    = 5;
  localparam int unsigned POS_W      = 4;

  // direction codes
  localparam logic ACT_S2H = 1'b0;
  localparam logic ACT_H2S = 1'b1;

  // single exponent field thresholds for the narrowing path
  localparam logic [S_EXP_W-1:0] S_EXP_UNDER  = 8'd102;  // below: flushed to +0
  localparam logic [S_EXP_W-1:0] S_EXP_DENMAX = 8'd112;  // up to here: half denormal
  localparam logic [S_EXP_W-1:0] S_EXP_OVER   = 8'd143;  // from here: infinity
  localparam logic [S_EXP_W-1:0] S_EXP_ONES   = 8'hFF;
  localparam logic [S_EXP_W-1:0] REBIAS       = 8'd112;  // 127 - 15
  localparam logic [S_EXP_W-1:0] DEN_SHIFT_OFS = 8'd126; // 113 - e plus 13 mantissa gap
  localparam logic [S_EXP_W-1:0] DEN_EXP_OFS  = 8'd103;  // 127 - 15 - 10 + 1

  localparam logic [H_EXP_W-1:0]  H_EXP_ONES  = 5'h1F;
  localparam logic [H_MANT_W-1:0] H_MANT_ONES = 10'h3FF;
  localparam logic [POS_W-1:0]    H_MANT_BITS = 4'd10;

  typedef enum logic [2:0] {
    CLS_ZERO,
    CLS_DEN,
    CLS_NORM,
    CLS_INF,
    CLS_NAN
  } cls_e;

endpackage

@@ hdl/hsfc_if.sv @@
// valid/ready channel interfaces of the half/single float converter
// depends on hsfc_pkg for the payload widths
interface hsfc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [hsfc_pkg::WORD_W-1:0] operand;
  logic                        item_last;

  modport source (output valid, action, operand, item_last, input ready);
  modport sink (input valid, action, operand, item_last, output ready);
endinterface

interface hsfc_out_if;
  logic                        valid;
  logic                        ready;
  logic [hsfc_pkg::WORD_W-1:0] converted;
  logic                        result_last;

  modport source (output valid, converted, result_last, input ready);
  modport sink (input valid, converted, result_last, output ready);
endinterface

@@ hdl/half_single_float_converter_top.sv @@
// half/single float converter, three register stages
// depends on hsfc_pkg, hsfc_if.sv (channel interfaces) and assert_macros.svh
//
// usage:
// - src_i carries one operand per transfer: action 0 narrows a single pattern
//   to half, action 1 widens the half pattern in operand[15:0] to single
// - dst_o returns one converted pattern per item, half results zero-extended,
//   with result_last a copy of item_last
// - an input transfer reaches valid on dst_o through the three stages (classify
//   and leading-one search, mantissa shift, result assembly), each registered
// - throughput is one item per cycle while dst_o is not stalled
// - when dst_o is stalled with a result waiting, the whole pipe holds and
//   src_i.ready drops; nothing is dropped or repeated, and empty stages do
//   not block the pipe from moving
// - reset clears the stage valid bits only; there is no state between items
`include "assert_macros.svh"

module half_single_float_converter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  hsfc_in_if.sink     src_i,
  hsfc_out_if.source  dst_o
);

  // pipe advance: move when the output slot is empty or being taken
  logic adv;
  assign adv         = !dst_o.valid || dst_o.ready;
  assign src_i.ready = adv;

  // ---------------------------------------------------------------------------
  // stage 1: classify the operand, leading-one search for half denormals
  // ---------------------------------------------------------------------------
  logic                              s1_vld_q;
  logic                              s1_dir_q, s1_last_q, s1_sign_q;
  hsfc_pkg::cls_e                    s1_cls_q;
  logic [hsfc_pkg::S_EXP_W-1:0]      s1_exp_q;
  logic [hsfc_pkg::S_MANT_W-1:0]     s1_mant_q;
  logic [hsfc_pkg::SHAMT_W-1:0]      s1_shamt_q;

  logic                              s1_sign_d;
  hsfc_pkg::cls_e                    s1_cls_d;
  logic [hsfc_pkg::S_EXP_W-1:0]      s1_exp_d;
  logic [hsfc_pkg::S_MANT_W-1:0]     s1_mant_d;
  logic [hsfc_pkg::SHAMT_W-1:0]      s1_shamt_d;

  logic [hsfc_pkg::S_EXP_W-1:0]      in_sexp;
  logic [hsfc_pkg::H_EXP_W-1:0]      in_hexp;
  logic [hsfc_pkg::H_MANT_W-1:0]     in_hmant;
  logic [hsfc_pkg::POS_W-1:0]        lead_pos;

  assign in_sexp  = src_i.operand[30:23];
  assign in_hexp  = src_i.operand[14:10];
  assign in_hmant = src_i.operand[9:0];

  // priority encoder: highest set bit wins
  always_comb begin
    lead_pos = '0;
    for (int i = 0; i < hsfc_pkg::H_MANT_W; i++) begin
      if (in_hmant[i]) begin
        lead_pos = hsfc_pkg::POS_W'(i);
      end
    end
  end

  always_comb begin
    s1_shamt_d = '0;
    if (src_i.action == hsfc_pkg::ACT_S2H) begin
      s1_sign_d = src_i.operand[31];
      s1_exp_d  = in_sexp;
      s1_mant_d = src_i.operand[22:0];
      if (in_sexp < hsfc_pkg::S_EXP_UNDER) begin
        // underflow flushes to +0, sign dropped
        s1_cls_d  = hsfc_pkg::CLS_ZERO;
        s1_sign_d = 1'b0;
      end else if (in_sexp <= hsfc_pkg::S_EXP_DENMAX) begin
        s1_cls_d   = hsfc_pkg::CLS_DEN;
        // total right shift including the 13-bit mantissa gap: 14..24
        s1_shamt_d = hsfc_pkg::SHAMT_W'(hsfc_pkg::DEN_SHIFT_OFS - in_sexp);
      end else if (in_sexp == hsfc_pkg::S_EXP_ONES) begin
        s1_cls_d = hsfc_pkg::CLS_NAN;  // inf handled as nan with empty payload
      end else if (in_sexp >= hsfc_pkg::S_EXP_OVER) begin
        s1_cls_d = hsfc_pkg::CLS_INF;
      end else begin
        s1_cls_d = hsfc_pkg::CLS_NORM;
      end
    end else begin
      s1_sign_d = src_i.operand[15];
      s1_exp_d  = hsfc_pkg::S_EXP_W'(in_hexp);
      s1_mant_d = hsfc_pkg::S_MANT_W'(in_hmant);
      if (in_hexp == '0) begin
        if (in_hmant == '0) begin
          s1_cls_d = hsfc_pkg::CLS_ZERO;
        end else begin
          s1_cls_d   = hsfc_pkg::CLS_DEN;
          s1_shamt_d = hsfc_pkg::SHAMT_W'(lead_pos);
        end
      end else if (in_hexp == hsfc_pkg::H_EXP_ONES) begin
        s1_cls_d = (in_hmant == '0) ? hsfc_pkg::CLS_INF : hsfc_pkg::CLS_NAN;
      end else begin
        s1_cls_d = hsfc_pkg::CLS_NORM;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: exponent rebias and mantissa shifts
  // ---------------------------------------------------------------------------
  logic                              s2_vld_q;
  logic                              s2_dir_q, s2_last_q, s2_sign_q;
  logic [hsfc_pkg::S_EXP_W-1:0]      s2_exp_q, s2_exp_d;
  logic [hsfc_pkg::S_MANT_W-1:0]     s2_mant_q, s2_mant_d;

  logic [hsfc_pkg::S_MANT_W:0]       den_full;
  logic [hsfc_pkg::H_MANT_W-1:0]     nan_trunc;
  logic [hsfc_pkg::H_MANT_W-1:0]     h_mant;
  logic [hsfc_pkg::H_MANT_W-1:0]     h_norm;
  logic [hsfc_pkg::POS_W-1:0]        h_lsh;

  assign den_full  = {1'b1, s1_mant_q} >> s1_shamt_q;
  assign nan_trunc = s1_mant_q[22:13];
  assign h_mant    = s1_mant_q[hsfc_pkg::H_MANT_W-1:0];
  assign h_lsh     = hsfc_pkg::H_MANT_BITS - s1_shamt_q[hsfc_pkg::POS_W-1:0];
  assign h_norm    = h_mant << h_lsh;  // drops the leading one

  always_comb begin
    s2_exp_d  = '0;
    s2_mant_d = '0;
    if (s1_dir_q == hsfc_pkg::ACT_S2H) begin
      case (s1_cls_q)
        hsfc_pkg::CLS_ZERO: ;
        hsfc_pkg::CLS_DEN: begin
          s2_mant_d = hsfc_pkg::S_MANT_W'(den_full[hsfc_pkg::H_MANT_W-1:0]);
        end
        hsfc_pkg::CLS_NORM: begin
          s2_exp_d  = s1_exp_q - hsfc_pkg::REBIAS;
          s2_mant_d = hsfc_pkg::S_MANT_W'(nan_trunc);
        end
        hsfc_pkg::CLS_INF: begin
          s2_exp_d = hsfc_pkg::S_EXP_W'(hsfc_pkg::H_EXP_ONES);
        end
        hsfc_pkg::CLS_NAN: begin
          s2_exp_d = hsfc_pkg::S_EXP_W'(hsfc_pkg::H_EXP_ONES);
          // keep a nan a nan when the payload truncates to nothing
          if (s1_mant_q != '0 && nan_trunc == '0) begin
            s2_mant_d = hsfc_pkg::S_MANT_W'(1);
          end else begin
            s2_mant_d = hsfc_pkg::S_MANT_W'(nan_trunc);
          end
        end
        default: ;
      endcase
    end else begin
      case (s1_cls_q)
        hsfc_pkg::CLS_ZERO: ;
        hsfc_pkg::CLS_DEN: begin
          s2_exp_d  = hsfc_pkg::S_EXP_W'(s1_shamt_q) + hsfc_pkg::DEN_EXP_OFS;
          s2_mant_d = {h_norm, 13'b0};
        end
        hsfc_pkg::CLS_NORM: begin
          s2_exp_d  = s1_exp_q + hsfc_pkg::REBIAS;
          s2_mant_d = {h_mant, 13'b0};
        end
        hsfc_pkg::CLS_INF: begin
          s2_exp_d = hsfc_pkg::S_EXP_ONES;
        end
        hsfc_pkg::CLS_NAN: begin
          s2_exp_d = hsfc_pkg::S_EXP_ONES;
          if (h_mant == hsfc_pkg::H_MANT_ONES) begin
            s2_mant_d = '1;
          end else begin
            s2_mant_d = {h_mant, 13'b0};
          end
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: pack into the output format, output register
  // ---------------------------------------------------------------------------
  logic                          s3_vld_q;
  logic                          s3_last_q;
  logic [hsfc_pkg::WORD_W-1:0]   s3_word_q, s3_word_d;

  always_comb begin
    if (s2_dir_q == hsfc_pkg::ACT_S2H) begin
      s3_word_d = {16'b0, s2_sign_q, s2_exp_q[hsfc_pkg::H_EXP_W-1:0],
                   s2_mant_q[hsfc_pkg::H_MANT_W-1:0]};
    end else begin
      s3_word_d = {s2_sign_q, s2_exp_q, s2_mant_q};
    end
  end

  // valid bits, reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= src_i.valid;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dir_q   <= src_i.action;
      s1_last_q  <= src_i.item_last;
      s1_sign_q  <= s1_sign_d;
      s1_cls_q   <= s1_cls_d;
      s1_exp_q   <= s1_exp_d;
      s1_mant_q  <= s1_mant_d;
      s1_shamt_q <= s1_shamt_d;
      s2_dir_q   <= s1_dir_q;
      s2_last_q  <= s1_last_q;
      s2_sign_q  <= s1_sign_q;
      s2_exp_q   <= s2_exp_d;
      s2_mant_q  <= s2_mant_d;
      s3_last_q  <= s2_last_q;
      s3_word_q  <= s3_word_d;
    end
  end

  assign dst_o.valid       = s3_vld_q;
  assign dst_o.converted   = s3_word_q;
  assign dst_o.result_last = s3_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // a stalled result is neither lost nor replaced
  `HSFC_ASSERT_NEXT(a_out_held, s3_vld_q && !dst_o.ready, s3_vld_q && $stable(s3_word_q),
    "output result changed while stalled")
  // a half result never has bits above the low half set
  `HSFC_ASSERT_NEXT(a_half_zext, adv && s2_vld_q && s2_dir_q == hsfc_pkg::ACT_S2H,
    s3_word_q[31:16] == 16'b0, "half result not zero-extended")
  // normalized half denormals land in the single exponent range 103..112
  `HSFC_ASSERT_NEXT(a_den_exp,
    adv && s1_vld_q && s1_dir_q == hsfc_pkg::ACT_H2S && s1_cls_q == hsfc_pkg::CLS_DEN,
    s2_exp_q >= hsfc_pkg::DEN_EXP_OFS && s2_exp_q <= hsfc_pkg::REBIAS,
    "half denormal exponent out of range")
  // pipe holds when the output is stalled
  `HSFC_ASSERT_IMPL(a_stall_hold, s3_vld_q && !dst_o.ready, !src_i.ready,
    "input taken while output stalled")

endmodule

@@ verif/half_single_float_converter_top_tb.sv @@
// testbench for half_single_float_converter_top: directed and random conversions
// in both directions, checked against a bit-exact predictor in a scoreboard class
// depends on hsfc_pkg, the channel interfaces in hsfc_if.sv and the rtl top
`timescale 1ns / 1ps

module half_single_float_converter_top_tb;
  import hsfc_pkg::*;

  localparam int unsigned CLK_HALF    = 4;       // 8 ns period
  localparam int unsigned HOLD_CYCLES = 200;     // long receiver hold-off
  localparam int unsigned CYCLE_LIMIT = 400000;  // watchdog
  localparam int unsigned DRAIN_WAIT  = 10;      // pipe is three stages deep

  // one expected result: converted pattern plus the last flag
  typedef struct packed {
    logic [WORD_W-1:0] converted;
    logic              last;
  } conv_result_t;

  // predicts each conversion from the accepted input and checks the results in order
  class conversion_scoreboard;
    conv_result_t pending_conversions[$];
    int unsigned  mismatches;
    int unsigned  results_checked;
    int unsigned  narrow_items;
    int unsigned  widen_items;

    function new();
      mismatches      = 0;
      results_checked = 0;
      narrow_items    = 0;
      widen_items     = 0;
    endfunction

    // single pattern to half pattern, truncating
    function logic [15:0] narrow_to_half(logic [WORD_W-1:0] x);
      logic        sgn;
      int          e;
      logic [23:0] m;
      logic [9:0]  frac;
      sgn = x[31];
      e   = int'(x[30:23]) - int'(REBIAS);
      // far below the denormal range: flushed to +0, sign dropped
      if (e < -10) return 16'h0000;
      // half denormal: implicit one shifted in, may end up a signed zero
      if (e <= 0) begin
        m = {1'b1, x[22:0]} >> (1 - e);
        return {sgn, 5'd0, m[22:13]};
      end
      // single inf or nan; a nan whose kept bits are all zero gets a one
      if (x[30:23] == S_EXP_ONES) begin
        frac = x[22:13];
        if (x[22:0] != '0 && frac == '0) frac = 10'd1;
        return {sgn, H_EXP_ONES, frac};
      end
      // too large for half
      if (e > 30) return {sgn, H_EXP_ONES, 10'd0};
      return {sgn, e[4:0], x[22:13]};
    endfunction

    // half pattern to single pattern
    function logic [WORD_W-1:0] widen_to_single(logic [15:0] h);
      logic        sgn;
      logic [4:0]  he;
      logic [9:0]  hm;
      logic [9:0]  norm;
      logic [7:0]  se;
      int unsigned lead;
      sgn = h[15];
      he  = h[14:10];
      hm  = h[9:0];
      if (he == '0) begin
        if (hm == '0) return {sgn, 31'd0};
        // normalize the denormal by its leading one
        lead = 0;
        for (int unsigned i = 0; i < 10; i++) if (hm[i]) lead = i;
        norm = hm << (10 - lead);
        se   = 8'(lead) + DEN_EXP_OFS;
        return {sgn, se, norm, 13'd0};
      end
      if (he == H_EXP_ONES) begin
        if (hm == '0) return {sgn, S_EXP_ONES, 23'd0};
        if (hm == H_MANT_ONES) return {sgn, S_EXP_ONES, 23'h7FFFFF};
        return {sgn, S_EXP_ONES, hm, 13'd0};
      end
      se = {3'd0, he} + REBIAS;
      return {sgn, se, hm, 13'd0};
    endfunction

    function void note_input(logic act, logic [WORD_W-1:0] op, logic last);
      conv_result_t res;
      if (act == ACT_S2H) begin
        res.converted = {16'd0, narrow_to_half(op)};
        narrow_items++;
      end else begin
        res.converted = widen_to_single(op[15:0]);
        widen_items++;
      end
      res.last = last;
      pending_conversions.push_back(res);
    endfunction

    function void check_result(logic [WORD_W-1:0] conv, logic last);
      conv_result_t want;
      results_checked++;
      if (pending_conversions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result converted=%h last=%b", conv, last);
        return;
      end
      want = pending_conversions.pop_front();
      if (want.converted !== conv) begin
        mismatches++;
        if (mismatches <= 10)
          $display("converted mismatch: expected %h actual %h", want.converted, conv);
      end
      if (want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("last flag mismatch: expected %b actual %b", want.last, last);
      end
    endfunction

    function int unsigned pending();
      return pending_conversions.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        steady = 1'b0;    // both sides stop idling while set
  int unsigned hold_req = 0;     // bumped to ask the receiver for a hold-off

  conversion_scoreboard sb;

  hsfc_in_if  src ();
  hsfc_out_if dst ();

  half_single_float_converter_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .src_i  (src),
    .dst_o  (dst)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // monitors: every signal is written by nonblocking assignment, so at the
  // edge these reads see the values that made the transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (src.valid && src.ready)
        sb.note_input(src.action, src.operand, src.item_last);
      if (dst.valid && dst.ready)
        sb.check_result(dst.converted, dst.result_last);
    end
  end

  // receiver side: random stalls, plus a long hold-off counted here on request
  initial begin : receiver
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    dst.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
        dst.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        dst.ready <= 1'b0;
      end else begin
        dst.ready <= steady || ($urandom_range(99) >= 27);
      end
    end
  end

  // offer one item, idling first at random, and return once its transfer is done;
  // valid stays high so a following item goes out back to back
  task automatic send_item(input logic act, input logic [WORD_W-1:0] op, input logic last);
    while (!steady && $urandom_range(99) < 27) begin
      src.valid <= 1'b0;
      @(posedge clk_i);
    end
    src.valid     <= 1'b1;
    src.action    <= act;
    src.operand   <= op;
    src.item_last <= last;
    do @(posedge clk_i); while (!src.ready);
  endtask

  // random operands, weighted toward exponent boundaries and nan / denormal patterns
  task automatic send_random_items(input int unsigned count);
    logic            act;
    logic [WORD_W-1:0] op;
    int unsigned     pick;
    for (int unsigned n = 0; n < count; n++) begin
      act  = 1'($urandom_range(1));
      op   = $urandom;
      pick = $urandom_range(9);
      if (act == ACT_S2H) begin
        case (pick)
          4, 5, 6: op[30:23] = 8'($urandom_range(146, 98));  // around the half range
          7:       op[30:23] = $urandom_range(1) ? S_EXP_ONES : 8'h00;
          8: begin
            // only bits dropped by truncation left in the mantissa
            op[22:13] = 10'd0;
            if ($urandom_range(1)) op[30:23] = S_EXP_ONES;
          end
          9:       op[30:23] = S_EXP_ONES;
          default: ;
        endcase
      end else begin
        case (pick)
          5, 6:    op[14:10] = 5'd0;
          7:       op[14:10] = H_EXP_ONES;
          8:       op[9:0]   = H_MANT_ONES;
          9:       op[9:0]   = 10'd0;
          default: ;
        endcase
      end
      send_item(act, op, $urandom_range(7) == 0);
    end
  endtask

  // stop offering and wait for every expected result
  task automatic drain_results();
    src.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    sb = new();
    src.valid     <= 1'b0;
    src.action    <= ACT_S2H;
    src.operand   <= '0;
    src.item_last <= 1'b0;
    rst_ni        <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed narrowing: zeros, denormals, boundaries, inf and nan
    send_item(ACT_S2H, 32'h0000_0000, 1'b0);  // +0
    send_item(ACT_S2H, 32'h8000_0000, 1'b1);  // -0 flushes to +0
    send_item(ACT_S2H, 32'h0000_0001, 1'b0);  // single denormal
    send_item(ACT_S2H, 32'h3280_0000, 1'b0);  // just below the denormal range
    send_item(ACT_S2H, 32'hB300_0000, 1'b0);  // lowest denormal exponent, signed zero
    send_item(ACT_S2H, 32'h387F_FFFF, 1'b0);  // largest half denormal
    send_item(ACT_S2H, 32'h3880_0000, 1'b0);  // smallest half normal
    send_item(ACT_S2H, 32'h3F80_0000, 1'b0);  // 1.0
    send_item(ACT_S2H, 32'h477F_FFFF, 1'b0);  // largest half normal, truncated
    send_item(ACT_S2H, 32'h4780_0000, 1'b0);  // overflow to inf
    send_item(ACT_S2H, 32'hFF7F_FFFF, 1'b1);  // largest single, negative inf
    send_item(ACT_S2H, 32'h7F80_0000, 1'b0);  // +inf
    send_item(ACT_S2H, 32'hFF80_0000, 1'b0);  // -inf
    send_item(ACT_S2H, 32'h7F80_0001, 1'b0);  // nan with payload lost, forced nonzero
    send_item(ACT_S2H, 32'hFFFF_FFFF, 1'b0);  // negative nan, all ones
    // directed widening: zeros, denormals, the largest normal, inf, nan and ignored upper bits
    send_item(ACT_H2S, 32'h0000_0000, 1'b0);
    send_item(ACT_H2S, 32'h0000_8000, 1'b0);  // -0 kept
    send_item(ACT_H2S, 32'h0000_0001, 1'b0);  // smallest denormal
    send_item(ACT_H2S, 32'h0000_03FF, 1'b0);  // largest denormal
    send_item(ACT_H2S, 32'h0000_7BFF, 1'b0);  // largest normal
    send_item(ACT_H2S, 32'h0000_FC00, 1'b0);  // -inf
    send_item(ACT_H2S, 32'h0000_7FFF, 1'b0);  // all-ones nan mantissa
    send_item(ACT_H2S, 32'h0000_FE00, 1'b0);  // other nan
    send_item(ACT_H2S, 32'hFFFF_3C00, 1'b1);  // upper bits set, 1.0

    send_random_items(500);

    // a long stretch with neither side idling
    steady <= 1'b1;
    send_random_items(300);
    steady <= 1'b0;

    // receiver holds off while the sender keeps offering, filling the pipe
    hold_req <= hold_req + 1;
    send_random_items(150);
    drain_results();

    send_random_items(1000);
    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("covered %0d single-to-half and %0d half-to-single conversions",
             sb.narrow_items, sb.widen_items);
    $display("%0d results checked, %0d mismatches, %0d still expected",
             sb.results_checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog on the run length
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/hsfc_pkg.sv
hdl/hsfc_if.sv
hdl/half_single_float_converter_top.sv
verif/half_single_float_converter_top_tb.sv
